// ----- rtl/core/rpbu_pkg.sv -----
// Package with the constants, the pipeline stage type and the rounding multiply of the blend unit.
`default_nettype none

package rpbu_pkg;

    localparam int NUM_STAGES = 10;
    localparam int DIV_FIRST  = 5;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = 2;
    localparam int LAST       = NUM_STAGES - 1;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_COPY    = 3'd1;
    localparam logic [2:0] MODE_MERGE   = 3'd2;
    localparam logic [2:0] MODE_BW      = 3'd3;
    localparam logic [2:0] MODE_FORPATH = 3'd4;

    localparam logic       REG_MODE    = 1'b0;
    localparam logic       REG_OPACITY = 1'b1;

    localparam logic [14:0] LUMA_R     = 15'd30;
    localparam logic [14:0] LUMA_G     = 15'd59;
    localparam logic [14:0] LUMA_B     = 15'd11;
    // A luma below 128 after the divide by 100 is a weighted sum below 12800.
    localparam logic [14:0] LUMA_SPLIT = 15'(128 * 100);

    localparam logic [7:0]  FULL       = 8'd255;
    localparam logic signed [17:0] ROUND_BIAS = 18'sd128;

    typedef struct packed {
        logic [3:0][7:0]        b;
        logic [3:0][7:0]        f;
        logic [2:0]             mode;
        logic [7:0]             op;
        logic signed [17:0]     fa_t;
        logic [3:0][17:0]       mt;
        logic                   dark;
        logic [7:0]             fa;
        logic [3:0][7:0]        mg;
        logic signed [17:0]     bt;
        logic [2:0][15:0]       rem;
        logic [2:0]             neg;
        logic [2:0][7:0]        q;
        logic [7:0]             da;
        logic [3:0][7:0]        res;
    } t_stage;

    // Second half of the rounding multiply: ((t >>> 8) + t) >>> 8.
    function automatic logic signed [9:0] mround(input logic signed [17:0] t);
        logic signed [18:0] s;
        s = 19'(t) + 19'(t >>> 8);
        return 10'(s >>> 8);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgba_pixel_blend_unit.sv -----
// Top level of the RGBA pixel blend unit with its ten-stage compositing pipeline.
// An accepted transaction moves stage by stage to the output register, one pixel per cycle
// unless the output stalls; the normal-mode divide runs two quotient bits per stage.
// Each stage advances when it is empty or its successor advances, so bubbles are squeezed out.
// Reset is synchronous and active low; it clears the stage valid bits and sets the mode to
// normal and the opacity to 255.
`default_nettype none

module rgba_pixel_blend_unit
    import rpbu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // back_red, back_green, back_blue, back_alpha, front_red, front_green, front_blue,
    // front_alpha
    input  wire logic [63:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]      o_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [2:0]               r_mode;
    logic [7:0]               r_opacity;
    logic [NUM_STAGES-1:0]    r_vld;
    logic [NUM_STAGES-1:0]    en;
    t_stage                   r_st [NUM_STAGES];
    t_stage                   n_st [NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_opacity <= FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:    r_mode    <= i_cfg_data[2:0];
                REG_OPACITY: r_opacity <= i_cfg_data;
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    always_comb begin
        en[LAST] = !r_vld[LAST] || i_m_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[LAST];
    assign o_m_tdata  = r_st[LAST].res;

    always_comb begin
        logic signed [9:0]  diff;
        logic signed [18:0] prod;
        logic signed [9:0]  msum;
        logic [7:0]         mag;
        logic [15:0]        dvs;
        int                 bitpos;
        logic [7:0]         qs;

        qs           = '0;
        n_st[0]      = '0;
        n_st[0].b    = i_s_tdata[31:0];
        n_st[0].f    = i_s_tdata[63:32];
        n_st[0].mode = r_mode;
        n_st[0].op   = r_opacity;
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_st[k] = r_st[k-1];
        end

        // Stage 1: raw products of the opacity multiplies and the weighted luma test.
        n_st[1].fa_t = 18'(16'(n_st[1].f[3]) * 16'(n_st[1].op)) + ROUND_BIAS;
        for (int i = 0; i < 4; i++) begin
            diff = 10'(n_st[1].f[i]) - 10'(n_st[1].b[i]);
            prod = diff * $signed({1'b0, n_st[1].op});
            n_st[1].mt[i] = 18'(prod) + ROUND_BIAS;
        end
        n_st[1].dark = (15'(n_st[1].b[0]) * LUMA_R + 15'(n_st[1].b[1]) * LUMA_G
                        + 15'(n_st[1].b[2]) * LUMA_B) < LUMA_SPLIT;

        // Stage 2: scaled front alpha and the complete merge result.
        n_st[2].fa = 8'(mround(n_st[2].fa_t));
        msum = 10'(n_st[2].b[3]) + mround($signed(n_st[2].mt[3]));
        n_st[2].mg[3] = 8'(msum);
        for (int i = 0; i < 3; i++) begin
            if (msum == '0) begin
                n_st[2].mg[i] = '0;
            end else if (n_st[2].b[3] == '0) begin
                n_st[2].mg[i] = n_st[2].f[i];
            end else if (n_st[2].f[3] == '0) begin
                n_st[2].mg[i] = n_st[2].b[i];
            end else begin
                n_st[2].mg[i] = 8'(10'(n_st[2].b[i]) + mround($signed(n_st[2].mt[i])));
            end
        end

        // Stage 3: back alpha times front alpha, and divide numerators as sign and magnitude.
        n_st[3].bt = 18'(16'(n_st[3].b[3]) * 16'(n_st[3].fa)) + ROUND_BIAS;
        for (int i = 0; i < 3; i++) begin
            diff = 10'(n_st[3].f[i]) - 10'(n_st[3].b[i]);
            n_st[3].neg[i] = diff < 0;
            mag = n_st[3].neg[i] ? 8'(-diff) : 8'(diff);
            n_st[3].rem[i] = 16'(mag) * 16'(n_st[3].fa);
        end

        // Stage 4: destination alpha.
        n_st[4].da = 8'(10'(n_st[4].b[3]) + 10'(n_st[4].fa) - mround(n_st[4].bt));
        n_st[4].q  = '0;

        // Stages 5 to 8: restoring divide, two quotient bits per stage.
        for (int k = DIV_FIRST; k < DIV_FIRST + DIV_STAGES; k++) begin
            for (int j = 0; j < DIV_BITS; j++) begin
                bitpos = 7 - DIV_BITS * (k - DIV_FIRST) - j;
                dvs = 16'(n_st[k].da) << bitpos;
                for (int i = 0; i < 3; i++) begin
                    if (n_st[k].rem[i] >= dvs) begin
                        n_st[k].rem[i]         = n_st[k].rem[i] - dvs;
                        n_st[k].q[i][bitpos[2:0]] = 1'b1;
                    end
                end
            end
        end

        // Stage 9: mode selection into the output register.
        n_st[LAST].res = n_st[LAST].f;
        case (n_st[LAST].mode)
            MODE_NORMAL: begin
                if (n_st[LAST].b[3] == '0) begin
                    n_st[LAST].res[3] = n_st[LAST].fa;
                end else if (n_st[LAST].f[3] == '0) begin
                    n_st[LAST].res = n_st[LAST].b;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        qs = n_st[LAST].neg[i] ? 8'(-n_st[LAST].q[i]) : n_st[LAST].q[i];
                        n_st[LAST].res[i] = (n_st[LAST].da == '0) ? n_st[LAST].b[i]
                                                                 : 8'(n_st[LAST].b[i] + qs);
                    end
                    n_st[LAST].res[3] = n_st[LAST].da;
                end
            end
            MODE_MERGE: begin
                n_st[LAST].res = n_st[LAST].mg;
            end
            MODE_BW: begin
                if (n_st[LAST].b[3] != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_st[LAST].res[i] = n_st[LAST].dark ? FULL : 8'd0;
                    end
                    n_st[LAST].res[3] = FULL;
                end
            end
            MODE_FORPATH: begin
                n_st[LAST].res[3] = n_st[LAST].fa;
            end
            default: begin
                n_st[LAST].res = n_st[LAST].f;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // The pipeline refuses a transaction only when every stage holds a pixel.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> &r_vld)
        else $error("input blocked while a stage is empty");

    // Normal-mode composite alpha never falls below the back alpha.
    a_da_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_st[LAST].mode == MODE_NORMAL && r_st[LAST].b[3] != '0
         && r_st[LAST].f[3] != '0) |-> (o_m_tdata[31:24] >= r_st[LAST].b[3]))
        else $error("composite alpha below back alpha");

    // A stalled output holds its pixel into the next cycle.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && !i_m_tready) |=> (r_vld[LAST] && $stable(o_m_tdata)))
        else $error("output pixel changed under stall");

    // Black-and-white mode over a back of nonzero alpha gives a gray of full alpha.
    a_bw_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_st[LAST].mode == MODE_BW && r_st[LAST].b[3] != '0)
        |-> (o_m_tdata[31:24] == FULL && o_m_tdata[7:0] == o_m_tdata[15:8]
             && o_m_tdata[15:8] == o_m_tdata[23:16]))
        else $error("black-and-white result not gray");

endmodule

`default_nettype wire
